>>> hdl/mte_pkg.sv
// Package for the Morse text encoder: symbol codes, character constants,
// code tables and the character lookup function. No dependencies.
package mte_pkg;

  typedef logic [1:0] sym_t;

  localparam sym_t SYM_DOT        = 2'd0;
  localparam sym_t SYM_DASH       = 2'd1;
  localparam sym_t SYM_LETTER_GAP = 2'd2;
  localparam sym_t SYM_WORD_GAP   = 2'd3;

  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_COMMA     = 8'h2C;
  localparam logic [7:0] CH_HYPHEN    = 8'h2D;
  localparam logic [7:0] CH_PERIOD    = 8'h2E;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_DIGIT_0   = 8'h30;
  localparam logic [7:0] CH_DIGIT_9   = 8'h39;
  localparam logic [7:0] CH_COLON     = 8'h3A;
  localparam logic [7:0] CH_SEMICOLON = 8'h3B;
  localparam logic [7:0] CH_QUESTION  = 8'h3F;
  localparam logic [7:0] CH_UPPER_A   = 8'h41;
  localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
  localparam logic [7:0] CH_LOWER_A   = 8'h61;
  localparam logic [7:0] CH_LOWER_Z   = 8'h7A;
  localparam logic [7:0] CH_YO_UPPER  = 8'hA8;
  localparam logic [7:0] CH_YO_LOWER  = 8'hB8;
  localparam logic [7:0] CH_CYR_FIRST = 8'hC0;

  localparam int MAX_SYMS = 8;
  localparam int CNT_W    = $clog2(MAX_SYMS + 1);
  localparam int PAT_LEN  = MAX_SYMS - 1;

  localparam int CYR_IE = 5;

  // dash bits are left-justified: first symbol in the MSB, 1 = dash
  typedef struct packed {
    logic [2:0]         len;
    logic [PAT_LEN-1:0] dash;
  } pat_t;

  typedef struct packed {
    logic [CNT_W-1:0]      cnt;
    logic [2*MAX_SYMS-1:0] syms;
  } entry_t;

  localparam pat_t CYR_PAT [32] = '{
    '{3'd2, 7'b0100000}, '{3'd4, 7'b1000000}, '{3'd3, 7'b0110000}, '{3'd3, 7'b1100000},
    '{3'd3, 7'b1000000}, '{3'd1, 7'b0000000}, '{3'd4, 7'b0001000}, '{3'd4, 7'b1100000},
    '{3'd2, 7'b0000000}, '{3'd4, 7'b0111000}, '{3'd3, 7'b1010000}, '{3'd4, 7'b0100000},
    '{3'd2, 7'b1100000}, '{3'd2, 7'b1000000}, '{3'd3, 7'b1110000}, '{3'd4, 7'b0110000},
    '{3'd3, 7'b0100000}, '{3'd3, 7'b0000000}, '{3'd1, 7'b1000000}, '{3'd3, 7'b0010000},
    '{3'd4, 7'b0010000}, '{3'd4, 7'b0000000}, '{3'd4, 7'b1010000}, '{3'd4, 7'b1110000},
    '{3'd4, 7'b1111000}, '{3'd4, 7'b1101000}, '{3'd6, 7'b0110100}, '{3'd4, 7'b1011000},
    '{3'd4, 7'b1001000}, '{3'd7, 7'b0001000}, '{3'd4, 7'b0011000}, '{3'd4, 7'b0101000}
  };

  localparam logic [4:0] LATIN_TO_CYR [26] = '{
    5'd0,  5'd1,  5'd22, 5'd4,  5'd5,  5'd20, 5'd3,  5'd21, 5'd8,  5'd9,  5'd10, 5'd11, 5'd12,
    5'd13, 5'd14, 5'd15, 5'd25, 5'd16, 5'd17, 5'd18, 5'd19, 5'd6,  5'd2,  5'd28, 5'd27, 5'd7
  };

  localparam pat_t DIGIT_PAT [10] = '{
    '{3'd5, 7'b1111100}, '{3'd5, 7'b0111100}, '{3'd5, 7'b0011100}, '{3'd5, 7'b0001100},
    '{3'd5, 7'b0000100}, '{3'd5, 7'b0000000}, '{3'd5, 7'b1000000}, '{3'd5, 7'b1100000},
    '{3'd5, 7'b1110000}, '{3'd5, 7'b1111000}
  };

  localparam pat_t PAT_PERIOD    = '{3'd6, 7'b0101010};
  localparam pat_t PAT_COMMA     = '{3'd6, 7'b1100110};
  localparam pat_t PAT_COLON     = '{3'd6, 7'b1110000};
  localparam pat_t PAT_QUESTION  = '{3'd6, 7'b0011000};
  localparam pat_t PAT_HYPHEN    = '{3'd6, 7'b1000010};
  localparam pat_t PAT_SLASH     = '{3'd5, 7'b1001000};
  localparam pat_t PAT_SEMICOLON = '{3'd6, 7'b1010100};

  // full symbol run for one character; cnt of zero means no output
  function automatic entry_t lookup(input logic [7:0] c);
    pat_t       p;
    logic       hit;
    logic [7:0] off;
    entry_t     e;
    hit = 1'b1;
    p   = '0;
    off = '0;
    e   = '0;
    if (c >= CH_CYR_FIRST) begin
      p = CYR_PAT[c[4:0]];
    end else if (c == CH_YO_UPPER || c == CH_YO_LOWER) begin
      p = CYR_PAT[CYR_IE];
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      off = c - CH_UPPER_A;
      p   = CYR_PAT[LATIN_TO_CYR[off[4:0]]];
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      off = c - CH_LOWER_A;
      p   = CYR_PAT[LATIN_TO_CYR[off[4:0]]];
    end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
      off = c - CH_DIGIT_0;
      p   = DIGIT_PAT[off[3:0]];
    end else begin
      case (c)
        CH_PERIOD:    p = PAT_PERIOD;
        CH_COMMA:     p = PAT_COMMA;
        CH_COLON:     p = PAT_COLON;
        CH_QUESTION:  p = PAT_QUESTION;
        CH_HYPHEN:    p = PAT_HYPHEN;
        CH_SLASH:     p = PAT_SLASH;
        CH_SEMICOLON: p = PAT_SEMICOLON;
        default:      hit = 1'b0;
      endcase
    end
    if (c == CH_SPACE) begin
      e.cnt        = CNT_W'(2);
      e.syms[1:0]  = SYM_WORD_GAP;
      e.syms[3:2]  = SYM_LETTER_GAP;
    end else if (hit) begin
      e.cnt = CNT_W'(p.len) + CNT_W'(1);
      for (int i = 0; i < MAX_SYMS; i++) begin
        if (3'(i) < p.len) begin
          e.syms[2*i +: 2] = p.dash[PAT_LEN-1-i] ? SYM_DASH : SYM_DOT;
        end else if (3'(i) == p.len) begin
          e.syms[2*i +: 2] = SYM_LETTER_GAP;
        end
      end
    end
    return e;
  endfunction

endpackage

>>> hdl/morse_text_encoder.sv
// Morse text encoder top level: code table read stage and symbol serializer.
// Depends on mte_pkg.
//
// One character byte in Windows-1251 coding enters per accepted item. Its
// code is read from the character table into a registered lookup stage,
// then the serializer emits one symbol item per cycle while sym_stall is low:
// the dots and dashes followed by a letter gap flagged by last, or a word gap
// and a letter gap for a space. A character therefore occupies 2 to 8 symbol
// items on the output port (run length plus one); bytes without a code give no
// symbol. The serializer output register sets the rate: a new character is
// taken while the previous run is still being sent, so runs follow each other
// back to back.
module morse_text_encoder (
  input  logic              clk,
  input  logic              rst,
  input  logic              char_valid,
  output logic              char_stall,
  input  logic [7:0]        char_code,
  output logic              sym_valid,
  input  logic              sym_stall,
  output mte_pkg::sym_t     symbol,
  output logic              last
);
  import mte_pkg::*;

  logic                  a_valid;
  entry_t                a_entry;
  logic                  b_valid;
  logic [2*MAX_SYMS-1:0] b_syms;
  logic [CNT_W-1:0]      b_left;

  logic char_accept;
  logic sym_accept;
  logic b_last;
  logic b_free;
  logic a_move;
  logic a_empty;

  assign b_last      = (b_left == CNT_W'(1));
  assign sym_accept  = b_valid && !sym_stall;
  assign b_free      = !b_valid || (sym_accept && b_last);
  assign a_empty     = (a_entry.cnt == '0);
  assign a_move      = a_valid && (a_empty || b_free);
  assign char_stall  = a_valid && !a_move;
  assign char_accept = char_valid && !char_stall;

  assign sym_valid = b_valid;
  assign symbol    = b_syms[1:0];
  assign last      = b_last;

  // table read
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (char_accept) begin
      a_valid <= 1'b1;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
    if (char_accept) begin
      a_entry <= lookup(char_code);
    end
  end

  // serializer
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (a_move && !a_empty) begin
      b_valid <= 1'b1;
    end else if (sym_accept && b_last) begin
      b_valid <= 1'b0;
    end
    if (a_move && !a_empty) begin
      b_syms <= a_entry.syms;
      b_left <= a_entry.cnt;
    end else if (sym_accept) begin
      b_syms <= b_syms >> 2;
      b_left <= b_left - CNT_W'(1);
    end
  end

endmodule

>>> dv/tb_morse_text_encoder.sv
`timescale 1ns / 100ps
// Testbench for morse_text_encoder: directed and random character streams, mostly with
// random idling and back-pressure, each symbol checked against a local Morse predictor.
// Depends on mte_pkg and morse_text_encoder.
module tb_morse_text_encoder;
  import mte_pkg::*;

  localparam int IDLE_PCT    = 26;
  localparam int HOLD_CYCLES = 160;
  localparam int SETTLE_CYC  = 8;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    sym_t symbol;
    logic last;
  } morse_sym_t;

  logic       clk;
  logic       rst;
  logic       char_valid;
  logic       char_stall;
  logic [7:0] char_code;
  logic       sym_valid;
  logic       sym_stall;
  sym_t       symbol;
  logic       last;

  morse_sym_t pending_syms[$];
  int         error_count;
  bit         send_idle;
  bit         recv_idle;
  int         hold_requests;

  // Cyrillic A..Ya in alphabet order
  string cyr_runs [32] = '{
    ".-", "-...", ".--", "--.", "-..", ".", "...-", "--..",
    "..", ".---", "-.-", ".-..", "--", "-.", "---", ".--.",
    ".-.", "...", "-", "..-", "..-.", "....", "-.-.", "---.",
    "----", "--.-", ".--.-.", "-.--", "-..-", "...-...", "..--", ".-.-"
  };
  int latin_to_letter [26] = '{
    0, 1, 22, 4, 5, 20, 3, 21, 8, 9, 10, 11, 12,
    13, 14, 15, 25, 16, 17, 18, 19, 6, 2, 28, 27, 7
  };
  string digit_runs [10] = '{
    "-----", ".----", "..---", "...--", "....-",
    ".....", "-....", "--...", "---..", "----."
  };
  logic [7:0] punct_chars [7] = '{
    CH_PERIOD, CH_COMMA, CH_COLON, CH_QUESTION, CH_HYPHEN, CH_SLASH, CH_SEMICOLON
  };

  morse_text_encoder DUT (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_code  (char_code),
    .sym_valid  (sym_valid),
    .sym_stall  (sym_stall),
    .symbol     (symbol),
    .last       (last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #200000;
    $display("morse_text_encoder regression: fail");
    $finish;
  end

  function automatic string morse_run_for(input logic [7:0] c);
    logic [7:0] off;
    if (c >= CH_CYR_FIRST) return cyr_runs[c[4:0]];
    if (c == CH_YO_UPPER || c == CH_YO_LOWER) return cyr_runs[CYR_IE];
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      off = c - CH_UPPER_A;
      return cyr_runs[5'(latin_to_letter[off[4:0]])];
    end
    if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      off = c - CH_LOWER_A;
      return cyr_runs[5'(latin_to_letter[off[4:0]])];
    end
    if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
      off = c - CH_DIGIT_0;
      return digit_runs[off[3:0]];
    end
    case (c)
      CH_PERIOD:    return ".-.-.-";
      CH_COMMA:     return "--..--";
      CH_COLON:     return "---...";
      CH_QUESTION:  return "..--..";
      CH_HYPHEN:    return "-....-";
      CH_SLASH:     return "-..-.";
      CH_SEMICOLON: return "-.-.-.";
      default:      return "";
    endcase
  endfunction

  task automatic expect_runs(input logic [7:0] c);
    string run;
    if (c == CH_SPACE) begin
      pending_syms.push_back('{SYM_WORD_GAP, 1'b0});
      pending_syms.push_back('{SYM_LETTER_GAP, 1'b1});
      return;
    end
    run = morse_run_for(c);
    if (run.len() == 0) return;
    for (int i = 0; i < run.len() && i < PAT_LEN; i++) begin
      pending_syms.push_back('{(run[i] == "-") ? SYM_DASH : SYM_DOT, 1'b0});
    end
    pending_syms.push_back('{SYM_LETTER_GAP, 1'b1});
  endtask

  function automatic logic [7:0] pick_text_char();
    int roll;
    roll = $urandom_range(99);
    if (roll < 22) return CH_UPPER_A + 8'($urandom_range(25));
    if (roll < 40) return CH_LOWER_A + 8'($urandom_range(25));
    if (roll < 58) return CH_CYR_FIRST + 8'($urandom_range(63));
    if (roll < 61) return ($urandom_range(1) != 0) ? CH_YO_UPPER : CH_YO_LOWER;
    if (roll < 70) return CH_DIGIT_0 + 8'($urandom_range(9));
    if (roll < 78) return punct_chars[3'($urandom_range(6))];
    if (roll < 90) return CH_SPACE;
    return 8'($urandom_range(255));
  endfunction

  // caller is at a falling edge; returns at a falling edge with valid still high
  task automatic send_char(input logic [7:0] c);
    while (send_idle && $urandom_range(99) < IDLE_PCT) begin
      char_valid <= 1'b0;
      char_code  <= 8'($urandom_range(255));
      @(negedge clk);
    end
    char_valid <= 1'b1;
    char_code  <= c;
    do @(posedge clk); while (char_stall);
    expect_runs(c);
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    char_valid <= 1'b0;
    while (pending_syms.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic note_mismatch(input string msg);
    if (error_count < MAX_REPORTS) $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  // receiver: random stall, or a long hold when a test asks for one
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    sym_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        sym_stall <= 1'b1;
      end else begin
        sym_stall <= recv_idle && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin : sym_check
    morse_sym_t want;
    if (!rst && sym_valid && !sym_stall) begin
      if (pending_syms.size() == 0) begin
        note_mismatch($sformatf("unexpected symbol %0d last %0b", symbol, last));
      end else begin
        want = pending_syms.pop_front();
        if (symbol !== want.symbol || last !== want.last) begin
          note_mismatch($sformatf("symbol exp %0d got %0d, last exp %0b got %0b",
                                  want.symbol, symbol, want.last, last));
        end
      end
    end
  end

  task automatic test_directed();
    logic [7:0] chars [25] = '{
      8'h00, 8'hFF, 8'h0A, CH_SPACE, CH_UPPER_A, CH_UPPER_Z, CH_LOWER_A, CH_LOWER_Z,
      CH_DIGIT_0, CH_DIGIT_9, CH_PERIOD, CH_COMMA, CH_COLON, CH_QUESTION, CH_HYPHEN,
      CH_SLASH, CH_SEMICOLON, CH_YO_UPPER, CH_YO_LOWER, CH_CYR_FIRST,
      8'hDA, 8'hDD, 8'hFA, 8'h40, 8'h5B
    };
    send_idle = 1'b1;
    recv_idle = 1'b1;
    foreach (chars[i]) send_char(chars[i]);
    wait_for_drain();
  endtask

  task automatic test_random_text(input int n);
    send_idle = 1'b1;
    recv_idle = 1'b1;
    repeat (n) send_char(pick_text_char());
    wait_for_drain();
  endtask

  task automatic test_streaming(input int n);
    send_idle = 1'b0;
    recv_idle = 1'b0;
    repeat (n) send_char(pick_text_char());
    wait_for_drain();
  endtask

  task automatic test_output_hold(input int n);
    send_idle = 1'b0;
    recv_idle = 1'b1;
    hold_requests++;
    repeat (n) send_char(pick_text_char());
    wait_for_drain();
  endtask

  task automatic test_random_bytes(input int n);
    send_idle = 1'b1;
    recv_idle = 1'b1;
    repeat (n) send_char(8'($urandom_range(255)));
    wait_for_drain();
  endtask

  initial begin
    error_count   = 0;
    hold_requests = 0;
    send_idle     = 1'b0;
    recv_idle     = 1'b0;
    rst           = 1'b1;
    char_valid    = 1'b0;
    char_code     = 8'h00;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_random_text(155);
    test_streaming(80);
    test_output_hold(50);
    test_random_bytes(60);

    if (pending_syms.size() != 0) begin
      note_mismatch($sformatf("%0d symbols never arrived", pending_syms.size()));
    end
    if (error_count == 0) begin
      $display("morse_text_encoder regression: pass");
    end else begin
      $display("morse_text_encoder regression: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/mte_pkg.sv
hdl/morse_text_encoder.sv
dv/tb_morse_text_encoder.sv
